[rtl/nvf_pkg.sv]
// Shared widths, stage counts and step functions for the vector normalizer.
// Used by nvf_sqrt, nvf_div and vector_normalize_fixed. No dependencies.
`default_nettype none
package nvf_pkg;

    localparam int COMP_W    = 24;              // Q7.16 component
    localparam int MAG_W     = 24;              // magnitude, up to 2^23
    localparam int SQ_W      = 2 * MAG_W;       // one square
    localparam int PAIR_W    = SQ_W + 1;        // sum of two squares
    localparam int SUM_W     = SQ_W + 2;        // sum of four squares
    localparam int ROOT_W    = SUM_W / 2;       // floor sqrt, one bit per step
    localparam int REM_W     = ROOT_W + 2;      // sqrt partial remainder
    localparam int LEN_W     = ROOT_W;          // divisor
    localparam int QUO_W     = 31;              // quotient up to 2^30
    localparam int OUT_W     = 32;              // Q1.30 result
    localparam int SIZE_W    = 3;
    localparam int NUM_COMP  = 4;

    localparam logic [QUO_W-1:0] ONE_Q30 = QUO_W'(1) << 30;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_state_t;

    // One digit of the square root: take two radicand bits, decide one root bit.
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t cur, input logic [1:0] bits);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic             ge;
        sqrt_state_t      res;
        t     = {cur.rem, bits};
        trial = {2'b00, cur.root, 2'b01};
        ge    = (t >= trial);
        res.rem  = ge ? REM_W'(t - trial) : REM_W'(t);
        res.root = {cur.root[ROOT_W-2:0], ge};
        return res;
    endfunction

    // One restoring division step: shift in a zero, subtract when it fits.
    function automatic div_state_t div_step(input div_state_t cur, input logic [LEN_W-1:0] len);
        logic [LEN_W:0] r2;
        logic           ge;
        div_state_t     res;
        r2  = {cur.rem, 1'b0};
        ge  = (r2 >= {1'b0, len});
        res.rem = ge ? LEN_W'(r2 - {1'b0, len}) : LEN_W'(r2);
        res.quo = {cur.quo[QUO_W-2:0], ge};
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/nvf_sqrt.sv]
// Pipelined floor square root, one root bit per register stage.
// Depends on nvf_pkg.
`default_nettype none
module nvf_sqrt
    import nvf_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SUM_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root
);

    sqrt_state_t      st_reg   [ROOT_W];
    sqrt_state_t      st_next  [ROOT_W];
    logic [SUM_W-1:0] rad_reg  [ROOT_W];
    logic [SUM_W-1:0] rad_next [ROOT_W];

    always_comb
    begin
        sqrt_state_t zero_st;
        zero_st = '0;
        st_next[0]  = sqrt_step(zero_st, radicand[SUM_W-1 -: 2]);
        rad_next[0] = radicand;
        for (int k = 1; k < ROOT_W; k++)
        begin
            st_next[k]  = sqrt_step(st_reg[k-1], rad_reg[k-1][SUM_W-1-2*k -: 2]);
            rad_next[k] = rad_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                st_reg[k]  <= st_next[k];
                rad_reg[k] <= rad_next[k];
            end
        end
    end

    assign root = st_reg[ROOT_W-1].root;

endmodule
`default_nettype wire

[rtl/nvf_div.sv]
// Pipelined restoring divider for mag * 2^30 / len, one quotient bit per stage.
// Depends on nvf_pkg.
`default_nettype none
module nvf_div
    import nvf_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [MAG_W-1:0]  mag,
    input  logic [LEN_W-1:0]  len,
    output logic [QUO_W-1:0]  quo
);

    div_state_t       st_reg   [QUO_W];
    div_state_t       st_next  [QUO_W];
    logic [LEN_W-1:0] len_reg  [QUO_W];

    always_comb
    begin
        logic           ge0;
        logic [LEN_W:0] mag_ext;
        mag_ext = (LEN_W+1)'(mag);
        ge0     = (mag_ext >= {1'b0, len});
        st_next[0].rem = ge0 ? LEN_W'(mag_ext - {1'b0, len}) : LEN_W'(mag_ext);
        st_next[0].quo = QUO_W'(ge0);
        for (int k = 1; k < QUO_W; k++)
        begin
            st_next[k] = div_step(st_reg[k-1], len_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg[0] <= len;
            for (int k = 1; k < QUO_W; k++)
            begin
                len_reg[k] <= len_reg[k-1];
            end
            for (int k = 0; k < QUO_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign quo = st_reg[QUO_W-1].quo;

endmodule
`default_nettype wire

[rtl/vector_normalize_fixed.sv]
// Top level of the L2 vector normalizer: Q7.16 components in, Q1.30 unit vector out.
// Depends on nvf_pkg, nvf_sqrt and nvf_div.
// Stages from input word to output word: 4 input/square/sum stages,
//   25 square-root stages, 31 divider stages, 1 output stage.
// Throughput: one word per cycle; the whole pipeline advances together and holds on stall.
// Reset: asynchronous, clears all valid bits; data registers are not reset.
`default_nettype none
module vector_normalize_fixed
    import nvf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // comp_x [23:0], comp_y [47:24], comp_z [71:48], comp_w [95:72]
    input  logic [4*COMP_W-1:0]     s_axis_tdata,
    // vector_size [2:0]
    input  logic [SIZE_W-1:0]       s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // norm_x [31:0], norm_y [63:32], norm_z [95:64], norm_w [127:96]
    output logic [4*OUT_W-1:0]      m_axis_tdata,
    // zero_length [0]
    output logic                    m_axis_tuser
);

    // Stage map: 0 magnitudes, 1 squares, 2 pair sums, 3 full sum,
    // then the root pipeline, the divider pipeline and the output register.
    localparam int SQRT_FIRST = 4;
    localparam int DIV_FIRST  = SQRT_FIRST + ROOT_W;
    localparam int OUT_STAGE  = DIV_FIRST + QUO_W;
    localparam int NUM_STAGES = OUT_STAGE + 1;

    typedef struct packed {
        logic [NUM_COMP-1:0][MAG_W-1:0] mag;
        logic [NUM_COMP-1:0]            neg;
    } side_t;

    typedef struct packed {
        logic [NUM_COMP-1:0] neg;
        logic                zero;
    } dside_t;

    logic                 adv;
    logic [NUM_STAGES-1:0] valid_reg;

    // Front stages
    side_t                  a_reg;
    side_t                  b_reg;
    side_t                  c_reg;
    side_t                  d_reg;
    logic [SQ_W-1:0]        sq_reg   [NUM_COMP];
    logic [PAIR_W-1:0]      pair_reg [2];
    logic [SUM_W-1:0]       sum_reg;

    side_t                  a_next;
    side_t                  sside_reg [ROOT_W];
    dside_t                 dside_reg [QUO_W];

    logic [ROOT_W-1:0]      root;
    logic [QUO_W-1:0]       quo [NUM_COMP];
    logic [4*OUT_W-1:0]     tdata_next;
    logic                   zero_next;

    // Whole pipeline moves when the output word is empty or being taken.
    assign adv           = !valid_reg[OUT_STAGE] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = valid_reg[OUT_STAGE];

    // Magnitudes, with unused components dropped to zero. A size below 2 counts as 2,
    // above 4 as 4, so z is live from size 3 and w from size 4.
    always_comb
    begin
        logic [COMP_W-1:0] c;
        logic [NUM_COMP-1:0] used;
        used[0] = 1'b1;
        used[1] = 1'b1;
        used[2] = (s_axis_tuser >= SIZE_W'(3));
        used[3] = (s_axis_tuser >= SIZE_W'(4));
        for (int i = 0; i < NUM_COMP; i++)
        begin
            c = s_axis_tdata[i*COMP_W +: COMP_W];
            a_next.neg[i] = c[COMP_W-1] & used[i];
            if (!used[i])
                a_next.mag[i] = '0;
            else if (c[COMP_W-1])
                a_next.mag[i] = MAG_W'(-c);
            else
                a_next.mag[i] = MAG_W'(c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_axis_tvalid};
    end

    // Front datapath: square, pair sums, full sum; side data rides along.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;
            for (int i = 0; i < NUM_COMP; i++)
            begin
                sq_reg[i] <= a_reg.mag[i] * a_reg.mag[i];
            end
            b_reg <= a_reg;
            pair_reg[0] <= PAIR_W'(sq_reg[0]) + PAIR_W'(sq_reg[1]);
            pair_reg[1] <= PAIR_W'(sq_reg[2]) + PAIR_W'(sq_reg[3]);
            c_reg <= b_reg;
            sum_reg <= SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
            d_reg <= c_reg;
        end
    end

    nvf_sqrt u_sqrt
    (
        .clk      (clk),
        .en       (adv),
        .radicand (sum_reg),
        .root     (root)
    );

    // Hold magnitudes and signs alongside the root pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sside_reg[0] <= d_reg;
            for (int k = 1; k < ROOT_W; k++)
            begin
                sside_reg[k] <= sside_reg[k-1];
            end
        end
    end

    for (genvar g = 0; g < NUM_COMP; g++)
    begin : g_div
        nvf_div u_div
        (
            .clk (clk),
            .en  (adv),
            .mag (sside_reg[ROOT_W-1].mag[g]),
            .len (root),
            .quo (quo[g])
        );
    end

    // Signs and the zero-length flag alongside the dividers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0].neg  <= sside_reg[ROOT_W-1].neg;
            dside_reg[0].zero <= (root == '0);
            for (int k = 1; k < QUO_W; k++)
            begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // Clamp, restore sign, force zero on a zero length.
    always_comb
    begin
        logic [QUO_W-1:0] sat;
        logic [OUT_W-1:0] mag32;
        zero_next = dside_reg[QUO_W-1].zero;
        for (int i = 0; i < NUM_COMP; i++)
        begin
            sat   = (quo[i] > ONE_Q30) ? ONE_Q30 : quo[i];
            mag32 = OUT_W'(sat);
            if (zero_next)
                tdata_next[i*OUT_W +: OUT_W] = '0;
            else if (dside_reg[QUO_W-1].neg[i])
                tdata_next[i*OUT_W +: OUT_W] = OUT_W'(-mag32);
            else
                tdata_next[i*OUT_W +: OUT_W] = mag32;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_axis_tdata <= tdata_next;
            m_axis_tuser <= zero_next;
        end
    end

endmodule
`default_nettype wire

[rtl/nvf_checker.sv]
// Port-level checks for vector_normalize_fixed, bound to the top level.
// Depends on nvf_pkg.
`default_nettype none
module nvf_checker
    import nvf_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                s_axis_tvalid,
    input wire logic                s_axis_tready,
    input wire logic [4*COMP_W-1:0] s_axis_tdata,
    input wire logic [SIZE_W-1:0]   s_axis_tuser,
    input wire logic                m_axis_tvalid,
    input wire logic                m_axis_tready,
    input wire logic [4*OUT_W-1:0]  m_axis_tdata,
    input wire logic                m_axis_tuser
);

    // Stalled output word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    // Input side never stalls while the output side drains.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output free");

    // Zero length gives an all-zero vector.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero length with nonzero data");

    // Every component lies within plus or minus one in Q1.30.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[31:0])   <= 32'sh40000000 &&
             $signed(m_axis_tdata[31:0])   >= -32'sh40000000 &&
             $signed(m_axis_tdata[63:32])  <= 32'sh40000000 &&
             $signed(m_axis_tdata[63:32])  >= -32'sh40000000 &&
             $signed(m_axis_tdata[95:64])  <= 32'sh40000000 &&
             $signed(m_axis_tdata[95:64])  >= -32'sh40000000 &&
             $signed(m_axis_tdata[127:96]) <= 32'sh40000000 &&
             $signed(m_axis_tdata[127:96]) >= -32'sh40000000))
        else $error("component out of range");

endmodule

bind vector_normalize_fixed nvf_checker u_nvf_checker (.*);
`default_nettype wire
